@@ rtl/tgad_pkg.sv @@
// Package for the TGA image decoder: codes, phase and state types,
// header summary struct and a small color helper.
// No dependencies.
package tgad_pkg;

    localparam int DEF_MAX_WIDTH       = 4096;
    localparam int DEF_MAX_HEIGHT      = 4096;
    localparam int DEF_PALETTE_ENTRIES = 256;
    localparam int DEF_MIN_WIDTH       = 4;

    localparam int          HDR_LEN      = 18;
    localparam logic [7:0]  RUN_BIAS     = 8'd127;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  DEPTH_24     = 8'd24;
    localparam logic [7:0]  DEPTH_32     = 8'd32;
    localparam logic [7:0]  DEPTH_8      = 8'd8;

    localparam logic [7:0]  TYPE_MAPPED     = 8'd1;
    localparam logic [7:0]  TYPE_TRUE       = 8'd2;
    localparam logic [7:0]  TYPE_MAPPED_RLE = 8'd9;
    localparam logic [7:0]  TYPE_TRUE_RLE   = 8'd10;

    typedef enum logic [2:0] {
        ERR_OK      = 3'd0,
        ERR_TYPE    = 3'd1,
        ERR_HEADER  = 3'd2,
        ERR_PALETTE = 3'd3,
        ERR_SIZE    = 3'd4,
        ERR_TRUNC   = 3'd5
    } err_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_IDSKIP  = 3'd2,
        PH_PALETTE = 3'd3,
        PH_PKTHDR  = 3'd4,
        PH_PIXEL   = 3'd5,
        PH_STOP    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_TAKE = 2'd0,
        ST_PAL  = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    typedef struct packed {
        logic        mapped;
        logic        rle;
        logic        map32;
        logic        pix32;
        logic        flip;
        logic [7:0]  id_len;
        logic [7:0]  map_len;
        logic [15:0] width;
        logic [15:0] height;
        logic [23:0] base_start;
        err_t        err;
    } hdr_info_t;

    // Gathered BGR(A) bytes to ARGB; 24-bit colors are opaque.
    function automatic logic [31:0] to_argb(input logic [31:0] acc, input logic is32);
        to_argb = is32 ? acc : {ALPHA_OPAQUE, acc[23:0]};
    endfunction

endpackage

@@ rtl/tgad_byte_if.sv @@
// Byte stream channel of the TGA image decoder.
// Depends on nothing.
interface tgad_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, byte_value, first_byte, last_byte, input ready);
    modport sink   (input valid, byte_value, first_byte, last_byte, output ready);
endinterface

@@ rtl/tgad_run_if.sv @@
// Pixel run channel of the TGA image decoder.
// Imports tgad_pkg; the error code is carried as a plain 3-bit field.
interface tgad_run_if
    import tgad_pkg::*;
    ;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_argb;
    logic [23:0] first_address;
    logic [7:0]  run_length;
    logic        done_res;
    logic [2:0]  error_code;

    modport source (output valid, pixel_argb, first_address, run_length, done_res,
                    error_code, input ready);
    modport sink   (input valid, pixel_argb, first_address, run_length, done_res,
                    error_code, output ready);
endinterface

@@ rtl/tgad_palette_ram.sv @@
// Color map memory of the TGA image decoder, one write and one registered read port.
// Depends on nothing.
module tgad_palette_ram #(
    parameter int ENTRIES = 256,
    parameter int AW      = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [ENTRIES];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tgad_header.sv @@
// Header capture and checking for the TGA image decoder; also precomputes
// the frame address of the first row. Depends on tgad_pkg.
module tgad_header
    import tgad_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
    parameter int MIN_WIDTH       = DEF_MIN_WIDTH
) (
    input  logic       clk,
    input  logic       wr_en,
    input  logic [4:0] wr_idx,
    input  logic [7:0] wr_data,
    output hdr_info_t  info
);

    logic [7:0]  hdr_reg [HDR_LEN];
    logic [23:0] base_reg;
    logic [15:0] w16;
    logic [15:0] h16;
    logic [7:0]  itype;
    logic        is_tc;
    logic        bad_map;
    logic        bad_tc;
    logic        bad_size;
    logic [31:0] prod;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hdr_reg[wr_idx] <= wr_data;
        end
        base_reg <= prod[23:0];
    end

    assign w16   = {hdr_reg[13], hdr_reg[12]};
    assign h16   = {hdr_reg[15], hdr_reg[14]};
    assign itype = hdr_reg[2];
    assign is_tc = (itype == TYPE_TRUE) || (itype == TYPE_TRUE_RLE);
    // First row lands at the bottom of the frame when the image is stored bottom-up.
    assign prod  = (h16 - 16'd1) * w16;

    always_comb
    begin
        info.mapped     = (itype == TYPE_MAPPED) || (itype == TYPE_MAPPED_RLE);
        info.rle        = (itype == TYPE_MAPPED_RLE) || (itype == TYPE_TRUE_RLE);
        info.map32      = (hdr_reg[7] == DEPTH_32);
        info.pix32      = (hdr_reg[16] == DEPTH_32);
        info.flip       = ({hdr_reg[11], hdr_reg[10]} == 16'd0);
        info.id_len     = hdr_reg[0];
        info.map_len    = hdr_reg[5];
        info.width      = w16;
        info.height     = h16;
        info.base_start = info.flip ? base_reg : 24'd0;

        bad_map = (hdr_reg[1] != 8'd1) || (hdr_reg[3] != 8'd0) || (hdr_reg[4] != 8'd0)
               || (hdr_reg[6] != 8'd0)
               || ((hdr_reg[7] != DEPTH_24) && (hdr_reg[7] != DEPTH_32))
               || (hdr_reg[16] != DEPTH_8)
               || ({1'b0, hdr_reg[5]} > 9'(PALETTE_ENTRIES));
        bad_tc  = (hdr_reg[1] != 8'd0) || (hdr_reg[5] != 8'd0) || (hdr_reg[6] != 8'd0)
               || ((hdr_reg[16] != DEPTH_24) && (hdr_reg[16] != DEPTH_32));
        bad_size = ({1'b0, w16} < 17'(MIN_WIDTH)) || ({1'b0, w16} > 17'(MAX_WIDTH))
                || (h16 == 16'd0) || ({1'b0, h16} > 17'(MAX_HEIGHT));

        if (info.mapped)
        begin
            info.err = bad_map ? ERR_HEADER : (bad_size ? ERR_SIZE : ERR_OK);
        end
        else if (is_tc)
        begin
            info.err = bad_tc ? ERR_HEADER : (bad_size ? ERR_SIZE : ERR_OK);
        end
        else
        begin
            info.err = ERR_TYPE;
        end
    end

endmodule

@@ rtl/tga_image_decoder.sv @@
// Top level of the TGA image decoder: byte sequencer, run splitter and output register.
// Depends on tgad_pkg, tgad_byte_if, tgad_run_if, tgad_header and tgad_palette_ram.
//
//   Channel     Dir   Transfer carries
//   file_bytes  sink  byte_value, first_byte, last_byte
//   pixel_runs  src   pixel_argb, first_address, run_length, done_res, error_code
//
// A completed pixel is sent as one result per row segment it covers (at most
// 33 for a run of 128), after a color map memory read when the image is
// color-mapped; no byte is taken until its last segment is out. Header, ID and
// color map bytes go one per cycle while the output register is free.
// Reset is asynchronous and active low; it returns the decoder to idle, where
// bytes are dropped until one marked first_byte arrives. Results wait in a
// single output register; a stalled pixel_runs channel stops the run splitter
// and, once the register is full, the byte input as well.
module tga_image_decoder
    import tgad_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
    parameter int MIN_WIDTH       = DEF_MIN_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    tgad_byte_if.sink   file_bytes,
    tgad_run_if.source  pixel_runs
);

    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_HEIGHT + 1);
    localparam int XW     = (CW > 8) ? CW : 8;
    localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    hdr_info_t hdr;

    state_t         state_reg, state_next;
    phase_t         phase_reg, phase_next;
    logic [7:0]     pos_reg, pos_next;
    logic [31:0]    acc_reg, acc_next;
    logic [1:0]     bip_reg, bip_next;
    logic [7:0]     pkt_rem_reg, pkt_rem_next;
    logic           pkt_run_reg, pkt_run_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [23:0]    base_reg, base_next;
    logic [31:0]    color_reg, color_next;
    logic [7:0]     count_reg, count_next;
    logic           trunc_reg, trunc_next;

    logic           out_valid_reg, out_valid_next;
    logic [31:0]    out_color_reg, out_color_next;
    logic [23:0]    out_addr_reg, out_addr_next;
    logic [7:0]     out_len_reg, out_len_next;
    logic           out_done_reg, out_done_next;
    err_t           out_err_reg, out_err_next;

    logic           out_free;
    logic           in_fire;
    logic           hdr_we;
    logic           pal_we;
    logic           pal_re;
    logic [PAL_AW-1:0] pal_waddr;
    logic [PAL_AW-1:0] pal_raddr;
    logic [31:0]    pal_wdata;
    logic [31:0]    pal_rdata;

    // Per-byte working values.
    phase_t         ph;
    logic [7:0]     pos;
    logic [1:0]     bip;
    logic [31:0]    acc;
    logic [31:0]    acc_ins;
    logic           made;
    logic           busy;
    logic           go_after_id;
    logic           go_start;
    logic [8:0]     pos_inc;

    // Run splitter values.
    logic [CW-1:0]  w_c;
    logic [RW-1:0]  h_c;
    logic [XW-1:0]  room_x;
    logic [XW-1:0]  cnt_x;
    logic           fits;
    logic           img_end;
    logic [23:0]    w24;

    tgad_header #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .PALETTE_ENTRIES(PALETTE_ENTRIES),
        .MIN_WIDTH      (MIN_WIDTH)
    ) u_header (
        .clk    (clk),
        .wr_en  (hdr_we),
        .wr_idx (pos[4:0]),
        .wr_data(file_bytes.byte_value),
        .info   (hdr)
    );

    tgad_palette_ram #(
        .ENTRIES(PALETTE_ENTRIES),
        .AW     (PAL_AW)
    ) u_palette (
        .clk  (clk),
        .we   (pal_we),
        .waddr(pal_waddr),
        .wdata(pal_wdata),
        .re   (pal_re),
        .raddr(pal_raddr),
        .rdata(pal_rdata)
    );

    assign out_free         = !out_valid_reg || pixel_runs.ready;
    assign file_bytes.ready = (state_reg == ST_TAKE) && out_free;
    assign in_fire          = file_bytes.valid && file_bytes.ready;

    assign pixel_runs.valid         = out_valid_reg;
    assign pixel_runs.pixel_argb    = out_color_reg;
    assign pixel_runs.first_address = out_addr_reg;
    assign pixel_runs.run_length    = out_len_reg;
    assign pixel_runs.done_res      = out_done_reg;
    assign pixel_runs.error_code    = out_err_reg;

    // Header width and height are range checked before any pixel, so they fit.
    assign w_c    = hdr.width[CW-1:0];
    assign h_c    = hdr.height[RW-1:0];
    assign w24    = {8'd0, hdr.width};
    assign room_x = XW'(w_c - col_reg);
    assign cnt_x  = XW'(count_reg);
    assign fits   = cnt_x < room_x;
    assign img_end = !fits && ((row_reg + RW'(1)) == h_c);

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        acc_next      = acc_reg;
        bip_next      = bip_reg;
        pkt_rem_next  = pkt_rem_reg;
        pkt_run_next  = pkt_run_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        color_next    = color_reg;
        count_next    = count_reg;
        trunc_next    = trunc_reg;

        out_valid_next = out_valid_reg && !pixel_runs.ready;
        out_color_next = out_color_reg;
        out_addr_next  = out_addr_reg;
        out_len_next   = out_len_reg;
        out_done_next  = out_done_reg;
        out_err_next   = out_err_reg;

        hdr_we    = 1'b0;
        pal_we    = 1'b0;
        pal_re    = 1'b0;
        pal_waddr = pos_reg[PAL_AW-1:0];
        pal_raddr = acc_reg[PAL_AW-1:0];
        pal_wdata = 32'd0;

        ph          = file_bytes.first_byte ? PH_HEADER : phase_reg;
        pos         = file_bytes.first_byte ? 8'd0 : pos_reg;
        bip         = file_bytes.first_byte ? 2'd0 : bip_reg;
        acc         = file_bytes.first_byte ? 32'd0 : acc_reg;
        acc_ins     = acc | (32'(file_bytes.byte_value) << {bip, 3'b000});
        pos_inc     = {1'b0, pos} + 9'd1;
        made        = 1'b0;
        busy        = 1'b0;
        go_after_id = 1'b0;
        go_start    = 1'b0;

        case (state_reg)
            ST_TAKE:
            begin
                if (in_fire)
                begin
                    if (file_bytes.first_byte)
                    begin
                        pkt_rem_next = 8'd0;
                        pkt_run_next = 1'b0;
                    end
                    pos_next   = pos;
                    acc_next   = acc;
                    bip_next   = bip;
                    phase_next = ph;

                    case (ph)
                        PH_HEADER:
                        begin
                            hdr_we   = 1'b1;
                            pos_next = pos_inc[7:0];
                            if (pos_inc == 9'(HDR_LEN))
                            begin
                                pos_next = 8'd0;
                                if (hdr.err != ERR_OK)
                                begin
                                    made           = 1'b1;
                                    phase_next     = PH_STOP;
                                    out_valid_next = 1'b1;
                                    out_color_next = 32'd0;
                                    out_addr_next  = 24'd0;
                                    out_len_next   = 8'd0;
                                    out_done_next  = 1'b1;
                                    out_err_next   = hdr.err;
                                end
                                else if (hdr.id_len != 8'd0)
                                begin
                                    phase_next = PH_IDSKIP;
                                end
                                else
                                begin
                                    go_after_id = 1'b1;
                                end
                            end
                        end
                        PH_IDSKIP:
                        begin
                            pos_next = pos_inc[7:0];
                            if (pos_inc >= {1'b0, hdr.id_len})
                            begin
                                go_after_id = 1'b1;
                            end
                        end
                        PH_PALETTE:
                        begin
                            if (bip == (hdr.map32 ? 2'd3 : 2'd2))
                            begin
                                pal_we    = 1'b1;
                                pal_waddr = pos[PAL_AW-1:0];
                                pal_wdata = to_argb(acc_ins, hdr.map32);
                                pos_next  = pos_inc[7:0];
                                acc_next  = 32'd0;
                                bip_next  = 2'd0;
                                if (pos_inc >= {1'b0, hdr.map_len})
                                begin
                                    go_start = 1'b1;
                                end
                            end
                            else
                            begin
                                acc_next = acc_ins;
                                bip_next = bip + 2'd1;
                            end
                        end
                        PH_PKTHDR:
                        begin
                            if (file_bytes.byte_value > RUN_BIAS)
                            begin
                                pkt_run_next = 1'b1;
                                pkt_rem_next = file_bytes.byte_value - RUN_BIAS;
                            end
                            else
                            begin
                                pkt_run_next = 1'b0;
                                pkt_rem_next = file_bytes.byte_value + 8'd1;
                            end
                            acc_next   = 32'd0;
                            bip_next   = 2'd0;
                            phase_next = PH_PIXEL;
                        end
                        PH_PIXEL:
                        begin
                            if (!hdr.mapped && (bip != (hdr.pix32 ? 2'd3 : 2'd2)))
                            begin
                                acc_next = acc_ins;
                                bip_next = bip + 2'd1;
                            end
                            else
                            begin
                                acc_next = 32'd0;
                                bip_next = 2'd0;
                                if (hdr.mapped && (acc_ins[7:0] >= hdr.map_len))
                                begin
                                    made           = 1'b1;
                                    phase_next     = PH_STOP;
                                    out_valid_next = 1'b1;
                                    out_color_next = 32'd0;
                                    out_addr_next  = 24'd0;
                                    out_len_next   = 8'd0;
                                    out_done_next  = 1'b1;
                                    out_err_next   = ERR_PALETTE;
                                end
                                else
                                begin
                                    busy       = 1'b1;
                                    trunc_next = file_bytes.last_byte;
                                    color_next = to_argb(acc_ins, hdr.pix32);
                                    if (hdr.mapped)
                                    begin
                                        pal_re     = 1'b1;
                                        pal_raddr  = acc_ins[PAL_AW-1:0];
                                        state_next = ST_PAL;
                                    end
                                    else
                                    begin
                                        state_next = ST_EMIT;
                                    end
                                    // A run packet covers its whole count at once.
                                    if (hdr.rle && pkt_run_reg)
                                    begin
                                        count_next   = pkt_rem_reg;
                                        pkt_rem_next = 8'd0;
                                    end
                                    else
                                    begin
                                        count_next = 8'd1;
                                        if (hdr.rle && (pkt_rem_reg != 8'd0))
                                        begin
                                            pkt_rem_next = pkt_rem_reg - 8'd1;
                                        end
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (go_after_id)
                    begin
                        pos_next = 8'd0;
                        acc_next = 32'd0;
                        bip_next = 2'd0;
                        if (hdr.mapped && (hdr.map_len != 8'd0))
                        begin
                            phase_next = PH_PALETTE;
                        end
                        else
                        begin
                            go_start = 1'b1;
                        end
                    end

                    if (go_start)
                    begin
                        row_next     = '0;
                        col_next     = '0;
                        base_next    = hdr.base_start;
                        acc_next     = 32'd0;
                        bip_next     = 2'd0;
                        pkt_rem_next = 8'd0;
                        pkt_run_next = 1'b0;
                        phase_next   = hdr.rle ? PH_PKTHDR : PH_PIXEL;
                    end

                    // A stream that ends mid-image without a pixel gets its own report.
                    if (file_bytes.last_byte && !made && !busy
                        && (phase_next != PH_IDLE) && (phase_next != PH_STOP))
                    begin
                        phase_next     = PH_STOP;
                        out_valid_next = 1'b1;
                        out_color_next = 32'd0;
                        out_addr_next  = 24'd0;
                        out_len_next   = 8'd0;
                        out_done_next  = 1'b1;
                        out_err_next   = ERR_TRUNC;
                    end
                end
            end
            ST_PAL:
            begin
                color_next = pal_rdata;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_color_next = color_reg;
                    out_addr_next  = base_reg + 24'(col_reg);
                    out_len_next   = fits ? count_reg : room_x[7:0];
                    out_done_next  = 1'b0;
                    out_err_next   = ERR_OK;
                    count_next     = fits ? 8'd0 : (count_reg - room_x[7:0]);

                    if (fits)
                    begin
                        col_next = col_reg + cnt_x[CW-1:0];
                    end
                    else
                    begin
                        col_next = '0;
                        row_next = row_reg + RW'(1);
                        base_next = hdr.flip ? (base_reg - w24) : (base_reg + w24);
                    end

                    if (img_end)
                    begin
                        out_done_next = 1'b1;
                        phase_next    = PH_STOP;
                        state_next    = ST_TAKE;
                    end
                    else if (count_next == 8'd0)
                    begin
                        state_next = ST_TAKE;
                        if (hdr.rle && (pkt_rem_reg == 8'd0))
                        begin
                            phase_next = PH_PKTHDR;
                        end
                        // Stream ended inside the image: last segment carries the report.
                        if (trunc_reg)
                        begin
                            out_done_next = 1'b1;
                            out_err_next  = ERR_TRUNC;
                            phase_next    = PH_STOP;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_TAKE;
            phase_reg     <= PH_IDLE;
            pos_reg       <= 8'd0;
            acc_reg       <= 32'd0;
            bip_reg       <= 2'd0;
            pkt_rem_reg   <= 8'd0;
            pkt_run_reg   <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= 24'd0;
            count_reg     <= 8'd0;
            trunc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            bip_reg       <= bip_next;
            pkt_rem_reg   <= pkt_rem_next;
            pkt_run_reg   <= pkt_run_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            count_reg     <= count_next;
            trunc_reg     <= trunc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg     <= color_next;
        out_color_reg <= out_color_next;
        out_addr_reg  <= out_addr_next;
        out_len_reg   <= out_len_next;
        out_done_reg  <= out_done_next;
        out_err_reg   <= out_err_next;
    end

endmodule
